[rtl/mws_pkg.sv]
package mws_pkg;

    // fixed field widths
    localparam int LANES   = 4;
    localparam int FWD_W   = 15;
    localparam int YAW_W   = 16;
    localparam int TRIG_W  = 16;
    localparam int PROD_W  = TRIG_W + FWD_W;      // trig times speed
    localparam int VEL_W   = PROD_W + 2;          // vx - vy and vx + vy
    localparam int GAIN_W  = 20;
    localparam int SPIN_W  = 10;
    localparam int ROT_W   = SPIN_W + GAIN_W;
    localparam int LIN_W   = VEL_W + GAIN_W + 1;  // signed product with gain
    localparam int ROT_SH  = 27;
    localparam int SUM_W   = 59;
    localparam int FRAC_SH = 35;
    localparam int MAG_W   = 24;
    localparam int RPM_W   = 15;
    localparam int SPD_W   = 16;
    localparam int NUM_W   = MAG_W + RPM_W;
    localparam int QUO_W   = RPM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int unsigned TRIG_MAX   = 32767;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RATE     = 2'd3;

    localparam logic [RPM_W-1:0]  MAX_RPM_RST       = 15'd8000;
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = 20'd31949;
    localparam logic [GAIN_W-1:0] ROTATION_GAIN_RST = 20'd256;
    localparam logic [SPIN_W-1:0] SPIN_RATE_RST     = 10'd50;

    typedef struct packed {
        logic valid;
        logic offline;
    } mws_ctl_t;

    typedef logic [MAG_W-1:0] mws_mag_t;
    typedef logic signed [SPD_W-1:0] mws_spd_t;

endpackage

[rtl/mecanum_wheel_speed_solver_core.sv]
// Mecanum wheel speed solver. Each command transaction (forward and sideways
// speed in Q12 m/s, yaw code, spin enable, motors offline) yields exactly one
// wheel transaction with four rpm targets and a peak_limited flag. The command
// velocity is rotated by yaw through Q1.15 sine/cosine tables of
// SINE_TABLE_DEPTH entries, a spin term is added, mecanum inverse kinematics
// is applied with the linear and rotation gains, and when the largest wheel
// magnitude exceeds max_rpm all four are scaled by max_rpm/peak, truncated
// toward zero. The pipeline takes one command per cycle unless cmd_stall is
// high. Its stages are one table read stage, four kinematics stages (trig
// products, velocity sums, gain products, rpm truncation), peak and numerator
// stages, fifteen restoring division stages (one quotient bit each) and the
// output register. The whole pipe advances together, so a stalled wheel
// transaction holds the command side with cmd_stall. Config writes (cfg_ready
// is always high) must be issued only while the pipe is empty; unknown
// indexes cannot occur with the two-bit index.
module mecanum_wheel_speed_solver_core #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // command channel
    input  logic                                   cmd_valid,
    output logic                                   cmd_stall,
    input  logic signed [mws_pkg::FWD_W-1:0]       fwd_speed,
    input  logic signed [mws_pkg::FWD_W-1:0]       side_speed,
    input  logic signed [mws_pkg::YAW_W-1:0]       yaw_angle,
    input  logic                                   spin_enable,
    input  logic                                   motors_offline,

    // wheel channel
    output logic                                   wheel_valid,
    input  logic                                   wheel_stall,
    output logic signed [mws_pkg::SPD_W-1:0]       wheel_one_speed,
    output logic signed [mws_pkg::SPD_W-1:0]       wheel_two_speed,
    output logic signed [mws_pkg::SPD_W-1:0]       wheel_three_speed,
    output logic signed [mws_pkg::SPD_W-1:0]       wheel_four_speed,
    output logic                                   peak_limited,

    // config write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mws_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import mws_pkg::*;

    // pipe advance: everything moves unless the output transaction is held
    logic en;
    assign en        = !(wheel_valid && wheel_stall);
    assign cmd_stall = !en;
    assign cfg_ready = 1'b1;

    // config registers
    logic [RPM_W-1:0]  max_rpm_reg;
    logic [GAIN_W-1:0] linear_gain_reg;
    logic [GAIN_W-1:0] rotation_gain_reg;
    logic [SPIN_W-1:0] spin_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rpm_reg       <= MAX_RPM_RST;
            linear_gain_reg   <= LINEAR_GAIN_RST;
            rotation_gain_reg <= ROTATION_GAIN_RST;
            spin_rate_reg     <= SPIN_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_RPM:       max_rpm_reg       <= cfg_data[RPM_W-1:0];
                CFG_LINEAR_GAIN:   linear_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_ROTATION_GAIN: rotation_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_SPIN_RATE:     spin_rate_reg     <= cfg_data[SPIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // yaw table lookup
    mws_ctl_t                 cmd_ctl;
    mws_ctl_t                 trig_ctl;
    logic signed [TRIG_W-1:0] trig_sin;
    logic signed [TRIG_W-1:0] trig_cos;
    logic signed [FWD_W-1:0]  trig_fwd;
    logic signed [FWD_W-1:0]  trig_side;
    logic                     trig_spin;

    assign cmd_ctl.valid   = cmd_valid;
    assign cmd_ctl.offline = motors_offline;

    mws_trig_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctl_in      (cmd_ctl),
        .fwd_speed   (fwd_speed),
        .side_speed  (side_speed),
        .yaw_angle   (yaw_angle),
        .spin_enable (spin_enable),
        .ctl_out     (trig_ctl),
        .sin_out     (trig_sin),
        .cos_out     (trig_cos),
        .fwd_out     (trig_fwd),
        .side_out    (trig_side),
        .spin_out    (trig_spin)
    );

    // body-frame rotation and wheel mixing
    mws_ctl_t kin_ctl;
    mws_mag_t kin_mag [LANES];
    logic     kin_neg [LANES];

    mws_kinematics u_kin (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .ctl_in        (trig_ctl),
        .sin_in        (trig_sin),
        .cos_in        (trig_cos),
        .fwd_in        (trig_fwd),
        .side_in       (trig_side),
        .spin_in       (trig_spin),
        .linear_gain   (linear_gain_reg),
        .rotation_gain (rotation_gain_reg),
        .spin_rate     (spin_rate_reg),
        .ctl_out       (kin_ctl),
        .mag_out       (kin_mag),
        .neg_out       (kin_neg)
    );

    // peak search and proportional scaling
    mws_ctl_t div_ctl;
    mws_spd_t div_speed [LANES];
    logic     div_limited;

    mws_peak_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctl_in      (kin_ctl),
        .mag_in      (kin_mag),
        .neg_in      (kin_neg),
        .max_rpm     (max_rpm_reg),
        .ctl_out     (div_ctl),
        .speed_out   (div_speed),
        .limited_out (div_limited)
    );

    // output register
    logic     out_valid_reg;
    mws_spd_t out_speed_reg [LANES];
    logic     out_limited_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_speed_reg   <= div_speed;
            out_limited_reg <= div_limited;
        end
    end

    assign wheel_valid       = out_valid_reg;
    assign wheel_one_speed   = out_speed_reg[0];
    assign wheel_two_speed   = out_speed_reg[1];
    assign wheel_three_speed = out_speed_reg[2];
    assign wheel_four_speed  = out_speed_reg[3];
    assign peak_limited      = out_limited_reg;

    // every delivered wheel speed stays within the configured peak
    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid
        |-> wheel_one_speed <= $signed({1'b0, max_rpm_reg})
            && wheel_one_speed >= -$signed({1'b0, max_rpm_reg})
            && wheel_two_speed <= $signed({1'b0, max_rpm_reg})
            && wheel_two_speed >= -$signed({1'b0, max_rpm_reg})
            && wheel_three_speed <= $signed({1'b0, max_rpm_reg})
            && wheel_three_speed >= -$signed({1'b0, max_rpm_reg})
            && wheel_four_speed <= $signed({1'b0, max_rpm_reg})
            && wheel_four_speed >= -$signed({1'b0, max_rpm_reg}))
        else $error("wheel speed above max_rpm");

    // an offline command comes out as all zeros, never limited
    a_offline_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && div_ctl.valid && div_ctl.offline
        |=> wheel_valid && !peak_limited && wheel_one_speed == '0
            && wheel_two_speed == '0 && wheel_three_speed == '0
            && wheel_four_speed == '0)
        else $error("offline transaction not zeroed");

    // a held wheel transaction freezes the last pipe stage
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid && wheel_stall |=> $stable(div_ctl) && $stable(div_limited))
        else $error("pipe moved while output held");

endmodule

[rtl/mws_trig_rom.sv]
module mws_trig_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  mws_pkg::mws_ctl_t                  ctl_in,
    input  logic signed [mws_pkg::FWD_W-1:0]   fwd_speed,
    input  logic signed [mws_pkg::FWD_W-1:0]   side_speed,
    input  logic signed [mws_pkg::YAW_W-1:0]   yaw_angle,
    input  logic                               spin_enable,
    output mws_pkg::mws_ctl_t                  ctl_out,
    output logic signed [mws_pkg::TRIG_W-1:0]  sin_out,
    output logic signed [mws_pkg::TRIG_W-1:0]  cos_out,
    output logic signed [mws_pkg::FWD_W-1:0]   fwd_out,
    output logic signed [mws_pkg::FWD_W-1:0]   side_out,
    output logic                               spin_out
);
    import mws_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int MUL_W = YAW_W + IDX_W + 1;
    localparam longint unsigned DEPTH = longint'(SINE_TABLE_DEPTH);

    // taylor term divisors (2n)(2n+1) for n = 1..6
    localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42,
                                                   64'd72, 64'd110, 64'd156};

    // q15 magnitude of sin(pi/2 * m / depth), taylor series in q30
    function automatic logic signed [TRIG_W-1:0] quarter_sine(input longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (PI_Q30 * m + DEPTH) / (2 * DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 16384) >>> 15;
        if (acc > longint'(TRIG_MAX))
            acc = longint'(TRIG_MAX);
        return TRIG_W'(acc);
    endfunction

    function automatic logic signed [TRIG_W-1:0] wave(input longint unsigned a);
        longint unsigned am;
        longint unsigned q;
        longint unsigned r;
        logic signed [TRIG_W-1:0] res;
        am = a % (4 * DEPTH);
        q  = am / DEPTH;
        r  = am % DEPTH;
        case (q)
            0:       res = quarter_sine(r);
            1:       res = quarter_sine(DEPTH - r);
            2:       res = -quarter_sine(r);
            default: res = -quarter_sine(DEPTH - r);
        endcase
        return res;
    endfunction

    logic signed [TRIG_W-1:0] sin_tab [SINE_TABLE_DEPTH];
    logic signed [TRIG_W-1:0] cos_tab [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_tab
        localparam logic signed [TRIG_W-1:0] SIN_K = wave(4 * longint'(k));
        localparam logic signed [TRIG_W-1:0] COS_K = wave(4 * longint'(k) + DEPTH);
        assign sin_tab[k] = SIN_K;
        assign cos_tab[k] = COS_K;
    end

    logic [MUL_W-1:0] idx_prod;
    logic [IDX_W-1:0] idx;

    // index = yaw as unsigned times depth, top bits
    assign idx_prod = MUL_W'(unsigned'(yaw_angle)) * MUL_W'(SINE_TABLE_DEPTH);
    assign idx      = IDX_W'(idx_prod >> YAW_W);

    mws_ctl_t                 ctl_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [FWD_W-1:0]  fwd_reg;
    logic signed [FWD_W-1:0]  side_reg;
    logic                     spin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg  <= sin_tab[idx];
            cos_reg  <= cos_tab[idx];
            fwd_reg  <= fwd_speed;
            side_reg <= side_speed;
            spin_reg <= spin_enable;
        end
    end

    assign ctl_out  = ctl_reg;
    assign sin_out  = sin_reg;
    assign cos_out  = cos_reg;
    assign fwd_out  = fwd_reg;
    assign side_out = side_reg;
    assign spin_out = spin_reg;

endmodule

[rtl/mws_kinematics.sv]
module mws_kinematics (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  mws_pkg::mws_ctl_t                  ctl_in,
    input  logic signed [mws_pkg::TRIG_W-1:0]  sin_in,
    input  logic signed [mws_pkg::TRIG_W-1:0]  cos_in,
    input  logic signed [mws_pkg::FWD_W-1:0]   fwd_in,
    input  logic signed [mws_pkg::FWD_W-1:0]   side_in,
    input  logic                               spin_in,
    input  logic [mws_pkg::GAIN_W-1:0]         linear_gain,
    input  logic [mws_pkg::GAIN_W-1:0]         rotation_gain,
    input  logic [mws_pkg::SPIN_W-1:0]         spin_rate,
    output mws_pkg::mws_ctl_t                  ctl_out,
    output mws_pkg::mws_mag_t                  mag_out [mws_pkg::LANES],
    output logic                               neg_out [mws_pkg::LANES]
);
    import mws_pkg::*;

    // stage b: trig products
    mws_ctl_t                 ctl_b_reg;
    logic signed [PROD_W-1:0] sf_reg;
    logic signed [PROD_W-1:0] cs_reg;
    logic signed [PROD_W-1:0] cf_reg;
    logic signed [PROD_W-1:0] ss_reg;
    logic                     spin_b_reg;

    // stage c: rotated velocity combos and spin term
    mws_ctl_t                 ctl_c_reg;
    logic signed [VEL_W-1:0]  dif_reg;
    logic signed [VEL_W-1:0]  sum_reg;
    logic [ROT_W-1:0]         rot_c_reg;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;

    // stage d: linear gain products
    mws_ctl_t                 ctl_d_reg;
    logic signed [LIN_W-1:0]  pa_reg;
    logic signed [LIN_W-1:0]  pb_reg;
    logic [ROT_W-1:0]         rot_d_reg;

    // stage e: wheel magnitudes in rpm
    mws_ctl_t                 ctl_e_reg;
    mws_mag_t                 mag_reg [LANES];
    logic                     neg_reg [LANES];
    logic signed [SUM_W-1:0]  wsum [LANES];
    logic signed [SUM_W-1:0]  rot_ext;
    logic signed [SUM_W-1:0]  pa_ext;
    logic signed [SUM_W-1:0]  pb_ext;
    logic [SUM_W-1:0]         wabs [LANES];

    always_comb
    begin
        vx = VEL_W'(sf_reg) - VEL_W'(cs_reg);
        vy = VEL_W'(cf_reg) + VEL_W'(ss_reg);
    end

    always_comb
    begin
        rot_ext = $signed(SUM_W'(rot_d_reg) << ROT_SH);
        pa_ext  = SUM_W'(pa_reg);
        pb_ext  = SUM_W'(pb_reg);
        wsum[0] = pa_ext + rot_ext;
        wsum[1] = pb_ext + rot_ext;
        wsum[2] = rot_ext - pa_ext;
        wsum[3] = rot_ext - pb_ext;
        for (int l = 0; l < LANES; l++)
            wabs[l] = wsum[l][SUM_W-1] ? SUM_W'(-wsum[l]) : SUM_W'(wsum[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
        end
        else if (en)
        begin
            ctl_b_reg <= ctl_in;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
            ctl_e_reg <= ctl_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_reg     <= sin_in * fwd_in;
            cs_reg     <= cos_in * side_in;
            cf_reg     <= cos_in * fwd_in;
            ss_reg     <= sin_in * side_in;
            spin_b_reg <= spin_in;

            dif_reg   <= vx - vy;
            sum_reg   <= vx + vy;
            rot_c_reg <= spin_b_reg ? ROT_W'(spin_rate) * ROT_W'(rotation_gain) : '0;

            pa_reg    <= dif_reg * $signed({1'b0, linear_gain});
            pb_reg    <= sum_reg * $signed({1'b0, linear_gain});
            rot_d_reg <= rot_c_reg;

            for (int l = 0; l < LANES; l++)
            begin
                mag_reg[l] <= MAG_W'(wabs[l] >> FRAC_SH);
                neg_reg[l] <= wsum[l][SUM_W-1];
            end
        end
    end

    assign ctl_out = ctl_e_reg;
    assign mag_out = mag_reg;
    assign neg_out = neg_reg;

endmodule

[rtl/mws_peak_divider.sv]
module mws_peak_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  mws_pkg::mws_ctl_t           ctl_in,
    input  mws_pkg::mws_mag_t           mag_in [mws_pkg::LANES],
    input  logic                        neg_in [mws_pkg::LANES],
    input  logic [mws_pkg::RPM_W-1:0]   max_rpm,
    output mws_pkg::mws_ctl_t           ctl_out,
    output mws_pkg::mws_spd_t           speed_out [mws_pkg::LANES],
    output logic                        limited_out
);
    import mws_pkg::*;

    // stage f: peak magnitude
    mws_ctl_t  ctl_f_reg;
    mws_mag_t  mag_f_reg [LANES];
    logic      neg_f_reg [LANES];
    mws_mag_t  peak_f_reg;
    mws_mag_t  peak01;
    mws_mag_t  peak23;
    mws_mag_t  peak_next;

    always_comb
    begin
        peak01    = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
        peak23    = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
        peak_next = (peak01 > peak23) ? peak01 : peak23;
    end

    // step 0 holds numerators, step j+1 the state after quotient bit QUO_W-1-j
    mws_ctl_t         ctl_reg   [QUO_W+1];
    mws_mag_t         peak_reg  [QUO_W+1];
    logic             lim_reg   [QUO_W+1];
    logic [NUM_W-1:0] rem_reg   [QUO_W+1][LANES];
    logic [QUO_W-1:0] quo_reg   [QUO_W+1][LANES];
    logic             neg_reg   [QUO_W+1][LANES];
    mws_spd_t         raw_reg   [QUO_W+1][LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_f_reg  <= '0;
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_f_reg  <= ctl_in;
            ctl_reg[0] <= ctl_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_f_reg  <= mag_in;
            neg_f_reg  <= neg_in;
            peak_f_reg <= peak_next;

            peak_reg[0] <= peak_f_reg;
            lim_reg[0]  <= (peak_f_reg > MAG_W'(max_rpm)) && !ctl_f_reg.offline;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= NUM_W'(mag_f_reg[l]) * NUM_W'(max_rpm);
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= neg_f_reg[l];
                raw_reg[0][l] <= neg_f_reg[l] ? -SPD_W'(mag_f_reg[l]) : SPD_W'(mag_f_reg[l]);
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - j;

        logic [NUM_W-1:0] dvs;
        logic [NUM_W-1:0] rem_next [LANES];
        logic [QUO_W-1:0] quo_next [LANES];

        always_comb
        begin
            dvs = NUM_W'(peak_reg[j]) << BIT;
            for (int l = 0; l < LANES; l++)
            begin
                if (rem_reg[j][l] >= dvs)
                begin
                    rem_next[l] = rem_reg[j][l] - dvs;
                    quo_next[l] = quo_reg[j][l] | (QUO_W'(1) << BIT);
                end
                else
                begin
                    rem_next[l] = rem_reg[j][l];
                    quo_next[l] = quo_reg[j][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[j+1] <= '0;
            else if (en)
                ctl_reg[j+1] <= ctl_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                peak_reg[j+1] <= peak_reg[j];
                lim_reg[j+1]  <= lim_reg[j];
                rem_reg[j+1]  <= rem_next;
                quo_reg[j+1]  <= quo_next;
                neg_reg[j+1]  <= neg_reg[j];
                raw_reg[j+1]  <= raw_reg[j];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (ctl_reg[QUO_W].offline)
                speed_out[l] = '0;
            else if (lim_reg[QUO_W])
                speed_out[l] = neg_reg[QUO_W][l] ? -SPD_W'(quo_reg[QUO_W][l])
                                                 : SPD_W'(quo_reg[QUO_W][l]);
            else
                speed_out[l] = raw_reg[QUO_W][l];
        end
    end

    assign ctl_out     = ctl_reg[QUO_W];
    assign limited_out = lim_reg[QUO_W];

    // a finished scaled division leaves a remainder below the divisor
    a_rem_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[QUO_W].valid && lim_reg[QUO_W]
        |-> rem_reg[QUO_W][0] < NUM_W'(peak_reg[QUO_W])
            && rem_reg[QUO_W][3] < NUM_W'(peak_reg[QUO_W]))
        else $error("divider remainder not below peak");

endmodule
